[hdl/ptmt_pkg.sv]
package ptmt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 64;
    localparam int PRIO_W      = 16;
    localparam int DATA_W      = 32;

    // cells inspected per scan cycle at the head of the chain
    localparam int LANES       = 8;
    localparam int SCAN_STEPS  = (TABLE_DEPTH + LANES - 1) / LANES;
    localparam int CNT_W       = $clog2(SCAN_STEPS + 1);

    // stream payload layout
    localparam int S_TDATA_W   = 176;
    localparam int M_TDATA_W   = 40;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] addr;
        logic [KEY_WIDTH-1:0] mask;
        logic [PRIO_W-1:0]    prio;
        logic [DATA_W-1:0]    data;
    } t_rule;

    // command broadcast to every cell; rule.addr doubles as lookup key
    typedef struct packed {
        logic  insert;
        logic  load;
        logic  shift;
        t_rule rule;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } t_srch;

endpackage

[hdl/ptmt_cell.sv]
module ptmt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptmt_pkg::t_cmd  i_cmd,
    input  logic           i_prev_gt,
    input  logic           i_prev_valid,
    input  ptmt_pkg::t_rule i_prev_rule,
    input  ptmt_pkg::t_srch i_scan_in,
    output logic           o_gt,
    output logic           o_valid,
    output ptmt_pkg::t_rule o_rule,
    output ptmt_pkg::t_srch o_scan
);
    import ptmt_pkg::*;

    t_rule r_rule, n_rule;
    logic  r_valid, n_valid;
    t_srch r_scan, n_scan;

    // sorted descending, so this is true for a prefix of the chain
    assign o_gt = r_valid && (r_rule.prio > i_cmd.rule.prio);

    always_comb begin
        n_rule  = r_rule;
        n_valid = r_valid;
        n_scan  = r_scan;
        if (i_cmd.insert && !o_gt) begin
            if (i_prev_gt) begin
                n_rule  = i_cmd.rule;
                n_valid = 1'b1;
            end else begin
                n_rule  = i_prev_rule;
                n_valid = i_prev_valid;
            end
        end
        if (i_cmd.load) begin
            n_scan.hit  = r_valid &&
                          (((r_rule.addr ^ i_cmd.rule.addr) & r_rule.mask) == '0);
            n_scan.data = r_rule.data;
        end else if (i_cmd.shift) begin
            n_scan = i_scan_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule <= n_rule;
    end

    assign o_valid = r_valid;
    assign o_rule  = r_rule;
    assign o_scan  = r_scan;

endmodule

[hdl/ptmt_pick.sv]
module ptmt_pick (
    input  ptmt_pkg::t_srch i_lane [ptmt_pkg::LANES],
    output ptmt_pkg::t_srch o_first
);
    import ptmt_pkg::*;

    always_comb begin
        o_first = '0;
        for (int j = LANES - 1; j >= 0; j--) begin
            if (i_lane[j].hit) begin
                o_first = i_lane[j];
            end
        end
    end

endmodule

[hdl/priority_ternary_match_table.sv]
// Priority ternary match table.
// s_axis carries one item per beat: tuser is the kind (0 insert, 1 lookup),
// tdata holds key, mask, priority and payload. m_axis returns one result
// beat per item: hit, result data and the table-full flag.
// Rules sit one per cell in a chain kept in descending priority order.
// An insert compares its priority in every cell at once and the cells behind
// the insert point take their upstream neighbor's rule in the same cycle,
// so an insert is done in its accept cycle and its result shows in the next cycle.
// A lookup compares the key in every cell in its accept cycle, then the
// match flags shift toward the head of the chain, LANES cells per cycle;
// the head cells are checked each cycle and the scan stops at the first hit.
// The lookup result is registered when that scan ends; no new item is
// taken while a scan runs.
// Reset clears every valid flag, leaving an empty table; stored rules are
// not cleared. When m_axis stalls, the result beat holds, and a finished
// scan waits in the chain until the output register frees.
module priority_ternary_match_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[63:0], mask[127:64], priority_req[143:128], payload[175:144]
    input  logic [ptmt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit[0], result_data[32:1], full_res[33], zero[39:34]
    output logic [ptmt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import ptmt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SCAN_STEPS - 1);

    logic                  r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data, n_m_data;

    t_cmd  w_cmd;
    t_rule w_rule  [TABLE_DEPTH];
    logic  w_valid [TABLE_DEPTH];
    logic  w_gt    [TABLE_DEPTH];
    t_srch w_scan  [TABLE_DEPTH];
    t_srch w_lane  [LANES];
    t_srch w_first;

    logic w_accept, w_out_free, w_full, w_last;

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = w_valid[TABLE_DEPTH-1];
    assign w_last        = w_first.hit || (r_cnt == SCAN_LAST);

    always_comb begin
        w_cmd.rule.addr = s_axis_tdata[KEY_WIDTH-1:0];
        w_cmd.rule.mask = s_axis_tdata[64 +: KEY_WIDTH];
        w_cmd.rule.prio = s_axis_tdata[143:128];
        w_cmd.rule.data = s_axis_tdata[175:144];
        w_cmd.insert    = w_accept && (s_axis_tuser == KIND_INSERT) && !w_full;
        w_cmd.load      = w_accept && (s_axis_tuser == KIND_LOOKUP);
        w_cmd.shift     = (r_state == ST_SCAN) && !w_last;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic  w_pgt;
        logic  w_pvalid;
        t_rule w_prule;
        t_srch w_sin;

        if (i == 0) begin : g_head
            assign w_pgt    = 1'b1;
            assign w_pvalid = 1'b0;
            assign w_prule  = '0;
        end else begin : g_body
            assign w_pgt    = w_gt[i-1];
            assign w_pvalid = w_valid[i-1];
            assign w_prule  = w_rule[i-1];
        end

        if (i + LANES < TABLE_DEPTH) begin : g_feed
            assign w_sin = w_scan[i+LANES];
        end else begin : g_tail
            assign w_sin = '0;
        end

        ptmt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_gt    (w_pgt),
            .i_prev_valid (w_pvalid),
            .i_prev_rule  (w_prule),
            .i_scan_in    (w_sin),
            .o_gt         (w_gt[i]),
            .o_valid      (w_valid[i]),
            .o_rule       (w_rule[i]),
            .o_scan       (w_scan[i])
        );
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        if (j < TABLE_DEPTH) begin : g_real
            assign w_lane[j] = w_scan[j];
        end else begin : g_pad
            assign w_lane[j] = '0;
        end
    end

    ptmt_pick u_pick (
        .i_lane  (w_lane),
        .o_first (w_first)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == KIND_INSERT) begin
                        n_m_valid = 1'b1;
                        n_m_data  = {6'b0, w_full, {DATA_W{1'b0}}, 1'b0};
                    end else begin
                        n_state = ST_SCAN;
                        n_cnt   = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    if (w_out_free) begin
                        n_m_valid = 1'b1;
                        n_m_data  = {6'b0, 1'b0, w_first.data, w_first.hit};
                        n_state   = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
